>>> hdl/first_fit_chunk_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFCA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFCA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ffca_pkg.sv
// Shared types and constants of the first-fit chunk allocator.
`default_nettype none

package ffca_pkg;

   localparam int PAGE_BYTES_DEF  = 4096;
   localparam int CHUNK_BYTES_DEF = 8;

   localparam int ADDR_W   = 48;
   localparam int SIZE_W   = 16;
   localparam int FREED_W  = 13;
   localparam int STATUS_W = 3;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_BAD_SIZE  = 3'd1,
      STAT_NO_SPACE  = 3'd2,
      STAT_OUTSIDE   = 3'd3,
      STAT_NOT_USED  = 3'd4
   } status_type;

   // One entry of the chunk mark memory.
   typedef struct packed {
      logic used;
      logic run_end;
   } chunk_flags_type;

endpackage

`default_nettype wire

>>> hdl/ffca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffca_ram #(
   parameter int WIDTH  = 2,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/ffca_div.sv
// Division by a fixed divisor through reciprocal multiplication, two register stages.
`default_nettype none

module ffca_div #(
   parameter int DIVISOR = 8,
   parameter int DW      = 17,
   parameter int REM_W   = $clog2(DIVISOR) + 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DW-1:0]    dividend,
   output logic                  done,
   output logic      [DW-1:0]    quotient,
   output logic      [REM_W-1:0] remainder
);

   localparam int SHIFT = DW + $clog2(DIVISOR);
   localparam int MW    = DW + 1;
   localparam int PW    = DW + MW;
   // rounded-up reciprocal is exact for every dividend below 2^DW
   localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                              / longint'(DIVISOR);
   localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

   logic             valid1_ff;
   logic             done_ff;
   logic [DW-1:0]    num_ff;
   logic [DW-1:0]    quo1_ff, quo1_in;
   logic [DW-1:0]    quo_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [PW-1:0]    product;

   always_comb begin
      product = PW'(dividend) * PW'(RECIP_C);
      quo1_in = DW'(product >> SHIFT);
      rem_in  = REM_W'(num_ff - quo1_ff * DW'(DIVISOR));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         valid1_ff <= start;
         done_ff   <= valid1_ff;
      end
      if (start) begin
         num_ff  <= dividend;
         quo1_ff <= quo1_in;
      end
      if (valid1_ff) begin
         quo_ff <= quo1_ff;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> hdl/first_fit_chunk_allocator.sv
// Top level of the first-fit chunk allocator over one page.
//
//  channel  direction  handshake           payload
//  req      in         req_valid/ready     req_cmd, req_size_bytes, req_address
//  rsp      out        rsp_valid/ready     rsp_status, rsp_result_address, rsp_freed_bytes
//  csr      in         csr_wr_en           csr_wr_data (page base)
//
// One word at a time: the LOAD state starts the divider, and the DIV state waits for the quotient.
// Allocate then scans the mark memory one chunk per cycle, over at most NCHUNK chunks,
// and writes the run back one chunk per cycle; free clears one chunk per cycle.
// A response stall keeps a finished word in the FINISH state.
// After reset a clearing pass over all NCHUNK chunks runs with req_ready low.
// A finished word waits in the output register; the next request is taken meanwhile.
`default_nettype none
`include "first_fit_chunk_allocator_defines.svh"

module first_fit_chunk_allocator
   import ffca_pkg::*;
#(
   parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_cmd,
   input  wire logic [SIZE_W-1:0]   req_size_bytes,
   input  wire logic [ADDR_W-1:0]   req_address,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [ADDR_W-1:0]   rsp_result_address,
   output logic      [FREED_W-1:0]  rsp_freed_bytes,
   input  wire logic                csr_wr_en,
   input  wire logic [ADDR_W-1:0]   csr_wr_data
);

   localparam int NCHUNK = PAGE_BYTES / CHUNK_BYTES;
   localparam int AW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int CW     = $clog2(NCHUNK + 1);
   localparam int OW     = $clog2(PAGE_BYTES);
   localparam int REM_W  = $clog2(CHUNK_BYTES) + 1;
   localparam int FW     = $bits(chunk_flags_type);
   localparam int DIV_W  = SIZE_W + 1;
   localparam int SPAN   = NCHUNK * CHUNK_BYTES;

   localparam logic [AW-1:0] LAST_IDX = AW'(NCHUNK - 1);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_DIV,
      S_SCAN,
      S_WRITE,
      S_ADDR,
      S_FREE,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [ADDR_W:0]       diff_ff, diff_in;
   logic [CW-1:0]         need_ff, need_in;
   logic [CW-1:0]         len_ff, len_in;
   logic [AW-1:0]         start_ff, start_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         end_ff, end_in;
   logic                  first_ff, first_in;
   logic [OW-1:0]         offset_ff, offset_in;
   logic [AW-1:0]         clr_ff, clr_in;
   status_type            res_status_ff, res_status_in;
   logic [ADDR_W-1:0]     res_addr_ff, res_addr_in;
   logic [FREED_W-1:0]    res_freed_ff, res_freed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [FREED_W-1:0]    rsp_freed_ff, rsp_freed_in;
   logic [ADDR_W-1:0]     page_base_ff;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   chunk_flags_type       ram_wr_flags;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [FW-1:0]         ram_rd_data;
   chunk_flags_type       rd_flags;

   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quo;
   logic [REM_W-1:0]      div_rem;

   logic [ADDR_W-1:0]     diff_mag;
   logic                  chunk_free;
   logic [CW-1:0]         len_next;
   logic [AW-1:0]         start_next;
   logic                  bad_size;
   logic                  outside;

   ffca_ram #(
      .WIDTH  (FW),
      .DEPTH  (NCHUNK),
      .ADDR_W (AW)
   ) u_marks (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_flags),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ffca_div #(
      .DIVISOR (CHUNK_BYTES),
      .DW      (DIV_W),
      .REM_W   (REM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rd_flags     = chunk_flags_type'(ram_rd_data);
   assign diff_mag     = diff_ff[ADDR_W] ? ADDR_W'(-diff_ff) : diff_ff[ADDR_W-1:0];
   assign div_start    = (state_ff == S_LOAD);
   // an address less than one chunk below the base maps to chunk 0
   assign div_dividend = (cmd_ff == CMD_ALLOC) ? DIV_W'(size_ff)
                       : (diff_ff[ADDR_W] ? '0 : diff_ff[DIV_W-1:0]);

   // size and index checks once the quotient is ready
   assign bad_size = (size_ff < SIZE_W'(CHUNK_BYTES))
                  || ({1'b0, size_ff} > (SIZE_W+1)'(PAGE_BYTES))
                  || (div_rem != '0);
   assign outside  = diff_ff[ADDR_W] ? (diff_mag >= ADDR_W'(CHUNK_BYTES))
                                     : (diff_ff[ADDR_W-1:0] >= ADDR_W'(SPAN));

   assign chunk_free = !rd_flags.used;
   assign len_next   = chunk_free ? len_ff + 1'b1 : '0;
   assign start_next = (chunk_free && (len_ff == '0)) ? idx_ff : start_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      diff_in       = diff_ff;
      need_in       = need_ff;
      len_in        = len_ff;
      start_in      = start_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      first_in      = first_ff;
      offset_in     = offset_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_freed_in  = res_freed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_freed_in  = rsp_freed_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_flags = '0;
      ram_rd_en    = 1'b0;
      // next chunk is read while the current one is handled
      ram_rd_addr  = idx_ff + 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in       = cmd_type'(req_cmd);
               size_in      = req_size_bytes;
               diff_in      = {1'b0, req_address} - {1'b0, page_base_ff};
               res_addr_in  = '0;
               res_freed_in = '0;
               state_in     = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               if (cmd_ff == CMD_ALLOC) begin
                  if (bad_size) begin
                     res_status_in = STAT_BAD_SIZE;
                     state_in      = S_FINISH;
                  end else begin
                     need_in     = div_quo[CW-1:0];
                     len_in      = '0;
                     idx_in      = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = S_SCAN;
                  end
               end else begin
                  if (outside) begin
                     res_status_in = STAT_OUTSIDE;
                     state_in      = S_FINISH;
                  end else begin
                     idx_in      = div_quo[AW-1:0];
                     first_in    = 1'b1;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = div_quo[AW-1:0];
                     state_in    = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            ram_rd_en = 1'b1;
            len_in    = len_next;
            start_in  = start_next;
            if (len_next == need_ff) begin
               idx_in   = start_next;
               end_in   = idx_ff;
               state_in = S_WRITE;
            end else if (idx_ff == LAST_IDX) begin
               res_status_in = STAT_NO_SPACE;
               state_in      = S_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_WRITE: begin
            // run chunks are free, so their end marks are already clear
            ram_wr_en            = 1'b1;
            ram_wr_flags.used    = 1'b1;
            ram_wr_flags.run_end = (idx_ff == end_ff);
            offset_in            = OW'(32'(start_ff) * CHUNK_BYTES);
            idx_in               = idx_ff + 1'b1;
            if (idx_ff == end_ff) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            res_addr_in   = page_base_ff + ADDR_W'(offset_ff);
            res_status_in = STAT_OK;
            state_in      = S_FINISH;
         end
         S_FREE: begin
            ram_rd_en = 1'b1;
            if (first_ff && !rd_flags.used) begin
               res_status_in = STAT_NOT_USED;
               state_in      = S_FINISH;
            end else begin
               ram_wr_en    = 1'b1;
               first_in     = 1'b0;
               res_freed_in = res_freed_ff + FREED_W'(CHUNK_BYTES);
               idx_in       = idx_ff + 1'b1;
               if (rd_flags.run_end || (idx_ff == LAST_IDX)) begin
                  res_status_in = STAT_OK;
                  state_in      = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_freed_in  = res_freed_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         page_base_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            page_base_ff <= csr_wr_data;
         end
      end
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      diff_ff       <= diff_in;
      need_ff       <= need_in;
      len_ff        <= len_in;
      start_ff      <= start_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      first_ff      <= first_in;
      offset_ff     <= offset_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_freed_ff  <= res_freed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_freed_bytes    = rsp_freed_ff;

   `FFCA_ASSERT_NOW(a_free_no_overlap, clock, reset,
      (state_ff == S_FREE) && ram_wr_en, ram_wr_addr != ram_rd_addr,
      "free walk writes the entry it is reading")
   `FFCA_ASSERT_NOW(a_scan_len_bound, clock, reset,
      state_ff == S_SCAN, len_ff < need_ff,
      "scan run length passed the request")
   `FFCA_ASSERT_NOW(a_write_in_run, clock, reset,
      state_ff == S_WRITE, idx_ff <= end_ff,
      "run write ran past its end mark")
   `FFCA_ASSERT_NOW(a_div_done_waited, clock, reset,
      div_done, state_ff == S_DIV,
      "divider finished while not awaited")
   `FFCA_ASSERT_NXT(a_div_leaves, clock, reset,
      (state_ff == S_DIV) && div_done, state_ff != S_DIV,
      "quotient taken but divide wait kept")

endmodule

`default_nettype wire
